FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the reconstruction block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MLR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Types and constants of the MUSCL limited reconstruction block.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int MODE_W     = 3;
  localparam int KAPPA_W    = 18;
  localparam int BIAS_W     = 16;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  localparam int KAPPA_RST = 21845;
  localparam int BIAS_RST  = 1;

  typedef enum logic [MODE_W-1:0] {
    LIM_NONE        = 3'd0,
    LIM_VAN_LEER    = 3'd1,
    LIM_MINMOD      = 3'd2,
    LIM_SUPERBEE    = 3'd3,
    LIM_FIRST_ORDER = 3'd4
  } limiter_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMITER_MODE = 2'd0,
    REG_KAPPA        = 2'd1,
    REG_DIFF_BIAS    = 2'd2
  } reg_idx_e;

  // per-ratio classification carried alongside the divider
  typedef struct packed {
    logic neg;   // signs of numerator and divisor differ
    logic dz;    // divisor is zero
    logic nz;    // numerator is nonzero
    logic npos;  // numerator is positive
    logic big;   // quotient does not fit the divider's quotient width
  } ratio_flags_t;

endpackage

FILE: rtl/mlr_div.sv
// ----------------------------------------------------------------------------
// mlr_div
// Pipelined restoring divider, one quotient bit per stage.
// The dividend must be below den << QUO_W.
// ----------------------------------------------------------------------------
module mlr_div #(
  parameter int DEN_W  = 34,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int RW = DEN_W + QUO_W;

  logic [RW-1:0]     rem_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     trial;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [QUO_W-1:0]  quo_nx;
    logic [SIDE_W-1:0] side_in;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = RW'(den_in) << (QUO_W - 1 - k);
    assign take  = rem_in >= trial;

    always_comb begin
      quo_nx = quo_in;
      quo_nx[QUO_W-1-k] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= quo_nx;
        side_q[k] <= side_in;
      end
    end

    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? rem_in - trial : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o  = quo_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

FILE: rtl/mlr_limit.sv
// ----------------------------------------------------------------------------
// mlr_limit
// Slope limiter: maps a Q ratio to a limiter factor. Van Leer uses a
// pipelined divider; the other modes travel alongside it.
// ----------------------------------------------------------------------------
module mlr_limit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [mlr_pkg::MODE_W-1:0]   mode_i,
  input  logic signed [DATA_WIDTH-1:0] r_i,
  output logic [FRAC_BITS+1:0]         f_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int FW   = F + 2;
  localparam int CW   = ((DW > F + 2) ? DW : F + 2) + 2;
  localparam int LDW  = ((F > DW) ? F : DW) + 1;
  localparam int QW   = F + 1;
  localparam int NUMW = LDW + QW;

  localparam logic signed [CW-1:0] QC = CW'(1) <<< F;
  localparam logic signed [CW-1:0] Q2 = CW'(1) <<< (F + 1);

  logic signed [CW-1:0] rx, r2, sa, sb, sm, alt_c;
  logic                 vl_c;
  logic [NUMW-1:0]      num_d, num_q;
  logic [LDW-1:0]       den_d, den_q;
  logic [FW:0]          side_d, side_q, side_o;
  logic [QW-1:0]        quo;
  logic [FW-1:0]        f_q;

  always_comb begin
    rx = CW'(r_i);
    r2 = rx <<< 1;
    sa = (r2 < QC) ? r2 : QC;
    sb = (rx < Q2) ? rx : Q2;
    sm = (sb > sa) ? sb : sa;
    case (mode_i)
      mlr_pkg::LIM_NONE:     alt_c = QC;
      mlr_pkg::LIM_MINMOD:   alt_c = (rx > 0) ? ((rx > QC) ? QC : rx) : '0;
      mlr_pkg::LIM_SUPERBEE: alt_c = (sm > 0) ? sm : '0;
      default:               alt_c = '0;
    endcase
    vl_c = (mode_i == mlr_pkg::LIM_VAN_LEER);
    if (rx > 0) begin
      num_d = NUMW'($unsigned(r_i)) << (F + 1);
      den_d = (LDW'(1) << F) + LDW'($unsigned(r_i));
    end else begin
      num_d = '0;
      den_d = LDW'(1);
    end
    side_d = {FW'(alt_c), vl_c};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  mlr_div #(
    .DEN_W  (LDW),
    .QUO_W  (QW),
    .SIDE_W (FW + 1)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (side_q),
    .quo_o  (quo),
    .side_o (side_o)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= side_o[0] ? FW'(quo) : side_o[FW:1];
    end
  end

  assign f_o = f_q;

endmodule

FILE: rtl/mlr_blend.sv
// ----------------------------------------------------------------------------
// mlr_blend
// Kappa blend of two limited slopes added to a base value (subtracted when
// SUBTRACT is set), three stages: slope products, weight products, sum with shift and clip.
// ----------------------------------------------------------------------------
module mlr_blend #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int WEIGHT_W   = 19,
  parameter bit SUBTRACT   = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [FRAC_BITS+1:0]         fa_i,
  input  logic signed [DATA_WIDTH+1:0] da_i,
  input  logic [FRAC_BITS+1:0]         fb_i,
  input  logic signed [DATA_WIDTH+1:0] db_i,
  input  logic signed [WEIGHT_W-1:0]   wa_i,
  input  logic signed [WEIGHT_W-1:0]   wb_i,
  input  logic signed [DATA_WIDTH-1:0] base_i,
  input  logic                         sat_i,
  output logic signed [DATA_WIDTH-1:0] state_o,
  output logic                         sat_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int FW   = F + 2;
  localparam int DIFW = DW + 2;
  localparam int P1W  = FW + 1 + DIFW;
  localparam int PAW  = P1W - F;
  localparam int MW   = WEIGHT_W + PAW;
  localparam int SW   = MW + 1;
  localparam int TW   = SW - F - 2;
  localparam int RSW  = TW + 1;

  localparam logic signed [RSW-1:0] MAXR = RSW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [RSW-1:0] MINR = -MAXR - RSW'(1);

  logic signed [P1W-1:0] pa_q, pb_q;
  logic signed [DW-1:0]  base1_q, base2_q;
  logic                  sat1_q, sat2_q;
  logic signed [PAW-1:0] pa, pb;
  logic signed [MW-1:0]  ma_q, mb_q;
  logic signed [SW-1:0]  sum;
  logic signed [TW-1:0]  t;
  logic signed [RSW-1:0] res;
  logic signed [DW-1:0]  state_q;
  logic                  sat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= $signed({1'b0, fa_i}) * da_i;
      pb_q    <= $signed({1'b0, fb_i}) * db_i;
      base1_q <= base_i;
      sat1_q  <= sat_i;
    end
  end

  // floor by 2^F
  assign pa = pa_q[P1W-1:F];
  assign pb = pb_q[P1W-1:F];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= wa_i * pa;
      mb_q    <= wb_i * pb;
      base2_q <= base1_q;
      sat2_q  <= sat1_q;
    end
  end

  assign sum = SW'(ma_q) + SW'(mb_q);
  assign t   = sum[SW-1:F+2];
  assign res = SUBTRACT ? RSW'(base2_q) - RSW'(t) : RSW'(base2_q) + RSW'(t);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (res > MAXR) begin
        state_q <= MAXR[DW-1:0];
        sat_q   <= 1'b1;
      end else if (res < MINR) begin
        state_q <= MINR[DW-1:0];
        sat_q   <= 1'b1;
      end else begin
        state_q <= res[DW-1:0];
        sat_q   <= sat2_q;
      end
    end
  end

  assign state_o = state_q;
  assign sat_o   = sat_q;

endmodule

FILE: rtl/muscl_limited_reconstruction_unit.sv
// ----------------------------------------------------------------------------
// muscl_limited_reconstruction_unit
// MUSCL kappa face reconstruction with a selectable slope limiter.
// ----------------------------------------------------------------------------
// Takes one stencil word per cycle and returns the left and right face states
// for each word. Most of the pipeline depth is in the two bit-per-stage
// dividers in series: the slope ratio divider (DATA_WIDTH stages) and the van
// Leer divider (FRAC_BITS + 1 stages). The pipeline advances as a whole; it
// holds while a finished word is not taken. Words with cell_active low are
// dropped at entry. Write configuration only while the pipeline is empty.
`include "assert_macros.svh"

module muscl_limited_reconstruction_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [mlr_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [mlr_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // value_prev, value_here, value_next, value_after
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // cell_active
  input  logic [0:0]                              s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // left_state, right_state
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  // ratio_saturated, also set when a face state is clipped
  output logic [0:0]                              m_axis_tuser
);

  localparam int DW    = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DIFW  = DW + 2;
  localparam int FW    = F + 2;
  localparam int KW    = (F + 2 > mlr_pkg::KAPPA_W) ? F + 2 : mlr_pkg::KAPPA_W;
  localparam int WW    = KW + 1;
  localparam int BW    = DIFW + F + DW;
  localparam int RW    = DIFW + DW;
  localparam int OUT_W = ((2*DW+7)/8)*8;
  localparam int PLW   = 2*DW + 3*DIFW;
  localparam int PD    = DW + F + 5;
  localparam int SD    = F + 4;
  localparam int LAT   = DW + F + 11;
  localparam int FLW   = $bits(mlr_pkg::ratio_flags_t);

  localparam logic signed [KW-1:0] QK = KW'(1) <<< F;

  // configuration
  logic [mlr_pkg::MODE_W-1:0]  mode_q;
  logic signed [KW-1:0]        kappa_q, kappa_d;
  logic [mlr_pkg::BIAS_W-1:0]  bias_q;
  logic signed [WW-1:0]        wa, wb;

  always_comb begin
    kappa_d = KW'($signed(cfg_data_i[mlr_pkg::KAPPA_W-1:0]));
    if (kappa_d > QK) begin
      kappa_d = QK;
    end else if (kappa_d < -QK) begin
      kappa_d = -QK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mlr_pkg::LIM_VAN_LEER;
      kappa_q <= KW'(mlr_pkg::KAPPA_RST);
      bias_q  <= mlr_pkg::BIAS_W'(mlr_pkg::BIAS_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlr_pkg::REG_LIMITER_MODE: mode_q  <= cfg_data_i[mlr_pkg::MODE_W-1:0];
        mlr_pkg::REG_KAPPA:        kappa_q <= kappa_d;
        mlr_pkg::REG_DIFF_BIAS:    bias_q  <= cfg_data_i[mlr_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign wa = WW'(QK) - WW'(kappa_q);
  assign wb = WW'(QK) + WW'(kappa_q);

  // pipeline control
  logic en;
  logic vld_q [LAT];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid && s_axis_tuser[0];
      for (int i = 1; i < LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // stage 1: input
  logic signed [DW-1:0] vp_q, vh1_q, vn1_q, va_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vp_q  <= $signed(s_axis_tdata[DW-1:0]);
      vh1_q <= $signed(s_axis_tdata[2*DW-1:DW]);
      vn1_q <= $signed(s_axis_tdata[3*DW-1:2*DW]);
      va_q  <= $signed(s_axis_tdata[4*DW-1:3*DW]);
    end
  end

  // stage 2: biased differences
  logic signed [DIFW-1:0] dm2_q, dp2_q, dq2_q, bias_x;
  logic signed [DW-1:0]   vh2_q, vn2_q;

  assign bias_x = DIFW'(bias_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm2_q <= DIFW'(vh1_q) - DIFW'(vp_q) + bias_x;
      dp2_q <= DIFW'(vn1_q) - DIFW'(vh1_q) + bias_x;
      dq2_q <= DIFW'(va_q) - DIFW'(vn1_q) + bias_x;
      vh2_q <= vh1_q;
      vn2_q <= vn1_q;
    end
  end

  // stage 3: magnitudes
  logic [DIFW-1:0]        adm_q, adp_q, adq_q;
  logic signed [DIFW-1:0] dm3_q, dp3_q, dq3_q;
  logic signed [DW-1:0]   vh3_q, vn3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      adm_q <= dm2_q[DIFW-1] ? -dm2_q : dm2_q;
      adp_q <= dp2_q[DIFW-1] ? -dp2_q : dp2_q;
      adq_q <= dq2_q[DIFW-1] ? -dq2_q : dq2_q;
      dm3_q <= dm2_q;
      dp3_q <= dp2_q;
      dq3_q <= dq2_q;
      vh3_q <= vh2_q;
      vn3_q <= vn2_q;
    end
  end

  // stage 4: ratio setup; ratios are dp/dm, dm/dp, dp/dq, dq/dp
  logic [DIFW-1:0]         an [4];
  logic [DIFW-1:0]         ad [4];
  logic                    sn [4];
  logic                    sd [4];
  logic [RW-1:0]           num_q [4];
  logic [DIFW-1:0]         den_q [4];
  mlr_pkg::ratio_flags_t   fl_q  [4];
  logic [DW-1:0]           quo   [4];
  mlr_pkg::ratio_flags_t   fl_o  [4];

  always_comb begin
    an[0] = adp_q; ad[0] = adm_q; sn[0] = dp3_q[DIFW-1]; sd[0] = dm3_q[DIFW-1];
    an[1] = adm_q; ad[1] = adp_q; sn[1] = dm3_q[DIFW-1]; sd[1] = dp3_q[DIFW-1];
    an[2] = adp_q; ad[2] = adq_q; sn[2] = dp3_q[DIFW-1]; sd[2] = dq3_q[DIFW-1];
    an[3] = adq_q; ad[3] = adp_q; sn[3] = dq3_q[DIFW-1]; sd[3] = dp3_q[DIFW-1];
  end

  for (genvar k = 0; k < 4; k++) begin : g_ratio
    logic [BW-1:0]         shn;
    logic                  big;
    mlr_pkg::ratio_flags_t fl_d;

    assign shn = BW'(an[k]) << F;
    assign big = shn >= (BW'(ad[k]) << DW);

    always_comb begin
      fl_d.neg  = sn[k] ^ sd[k];
      fl_d.dz   = (ad[k] == '0);
      fl_d.nz   = (an[k] != '0);
      fl_d.npos = !sn[k] && (an[k] != '0);
      fl_d.big  = big;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[k] <= (big || fl_d.dz) ? '0 : RW'(shn);
        den_q[k] <= ad[k];
        fl_q[k]  <= fl_d;
      end
    end

    mlr_div #(
      .DEN_W  (DIFW),
      .QUO_W  (DW),
      .SIDE_W (FLW)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[k]),
      .den_i  (den_q[k]),
      .side_i (fl_q[k]),
      .quo_o  (quo[k]),
      .side_o (fl_o[k])
    );
  end

  // delay line for values and differences
  logic [PLW-1:0] pl_q [PD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_q[0] <= {vh3_q, vn3_q, dm3_q, dp3_q, dq3_q};
      for (int i = 1; i < PD; i++) begin
        pl_q[i] <= pl_q[i-1];
      end
    end
  end

  // stage 5: ratio result with saturation
  localparam logic [DW-1:0] RMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] RMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] r_c [4];
  logic                 rs_c [4];
  logic signed [DW-1:0] r_q [4];
  logic                 sr_q [SD];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rs_c[k] = 1'b0;
      if (fl_o[k].dz) begin
        rs_c[k] = fl_o[k].nz;
        r_c[k]  = !fl_o[k].nz ? '0 : (fl_o[k].npos ? RMAX : RMIN);
      end else if (fl_o[k].big) begin
        rs_c[k] = 1'b1;
        r_c[k]  = fl_o[k].neg ? RMIN : RMAX;
      end else if (fl_o[k].neg) begin
        rs_c[k] = quo[k] > RMIN;
        r_c[k]  = rs_c[k] ? RMIN : -quo[k];
      end else begin
        rs_c[k] = quo[k][DW-1];
        r_c[k]  = rs_c[k] ? RMAX : quo[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r_q[k] <= r_c[k];
      end
      sr_q[0] <= rs_c[0] | rs_c[1] | rs_c[2] | rs_c[3];
      for (int i = 1; i < SD; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  // limiters
  logic [FW-1:0] f [4];

  for (genvar k = 0; k < 4; k++) begin : g_lim
    mlr_limit #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (F)
    ) u_limit (
      .clk_i  (clk_i),
      .en_i   (en),
      .mode_i (mode_q),
      .r_i    (r_q[k]),
      .f_o    (f[k])
    );
  end

  // blend
  logic signed [DW-1:0]   vh_b, vn_b, left_state, right_state;
  logic signed [DIFW-1:0] dm_b, dp_b, dq_b;
  logic                   sat_l, sat_r;

  assign {vh_b, vn_b, dm_b, dp_b, dq_b} = pl_q[PD-1];

  mlr_blend #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (F),
    .WEIGHT_W   (WW),
    .SUBTRACT   (1'b0)
  ) u_blend_left (
    .clk_i   (clk_i),
    .en_i    (en),
    .fa_i    (f[0]),
    .da_i    (dm_b),
    .fb_i    (f[1]),
    .db_i    (dp_b),
    .wa_i    (wa),
    .wb_i    (wb),
    .base_i  (vh_b),
    .sat_i   (sr_q[SD-1]),
    .state_o (left_state),
    .sat_o   (sat_l)
  );

  mlr_blend #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (F),
    .WEIGHT_W   (WW),
    .SUBTRACT   (1'b1)
  ) u_blend_right (
    .clk_i   (clk_i),
    .en_i    (en),
    .fa_i    (f[2]),
    .da_i    (dq_b),
    .fb_i    (f[3]),
    .db_i    (dp_b),
    .wa_i    (wa),
    .wb_i    (wb),
    .base_i  (vn_b),
    .sat_i   (sr_q[SD-1]),
    .state_o (right_state),
    .sat_o   (sat_r)
  );

  assign m_axis_tdata    = OUT_W'({right_state, left_state});
  assign m_axis_tuser[0] = sat_l | sat_r;

  `MLR_ASSERT_NOW(a_stall_holds_input, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input accepted while output stalled")
  `MLR_ASSERT_NEXT(a_inactive_dropped, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], !vld_q[0], "inactive cell entered pipeline")
  `MLR_ASSERT_NEXT(a_valid_advances, clk_i, rst_ni, en && vld_q[0], vld_q[1], "valid bit lost in pipeline")

endmodule
